>>> rtl/assert_macros.svh
// Assertion macros used by the checker module of the alert pattern sequencer.
// No dependencies; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define APS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define APS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/aps_pkg.sv
// Package of the alert pattern sequencer: codes, item types, register defaults
// and the fixed beep tables. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aps_pkg;

  localparam int TIMER_BITS_DEF = 10;
  localparam int CFG_BITS       = 10;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_BUZZ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_DEBOUNCE     = 3'd0,
    CFG_FLASH_PERIOD = 3'd1,
    CFG_PULSE_SHORT  = 3'd2,
    CFG_PULSE_MEDIUM = 3'd3,
    CFG_PULSE_LONG   = 3'd4,
    CFG_PULSE_OFF    = 3'd5,
    CFG_PULSE_COUNT  = 3'd6,
    CFG_NONE         = 3'd7
  } cfg_idx_t;

  // Alert levels that act, and the pin bit positions.
  localparam logic [3:0] LVL_FIRST  = 4'd6;
  localparam logic [3:0] LVL_PULSED = 4'd8;
  localparam logic [3:0] LVL_FLASH  = 4'd10;
  localparam logic [3:0] TRACK_BASE = 4'd5;

  localparam int PIN_BUZ  = 0;
  localparam int PIN_MAIN = 1;
  localparam int PIN_SEC  = 2;

  typedef struct packed {
    logic [CFG_BITS-1:0] debounce_ms;
    logic [CFG_BITS-1:0] flash_period_ms;
    logic [CFG_BITS-1:0] pulse_on_short_ms;
    logic [CFG_BITS-1:0] pulse_on_medium_ms;
    logic [CFG_BITS-1:0] pulse_on_long_ms;
    logic [CFG_BITS-1:0] pulse_off_ms;
    logic [1:0]          pulse_count;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    debounce_ms:        10'd200,
    flash_period_ms:    10'd400,
    pulse_on_short_ms:  10'd200,
    pulse_on_medium_ms: 10'd400,
    pulse_on_long_ms:   10'd600,
    pulse_off_ms:       10'd150,
    pulse_count:        2'd3
  };

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] level;
    logic       button_pressed;
  } in_item_t;

  typedef struct packed {
    logic       buzzer;
    logic       led_main;
    logic       led_second;
    logic       alert_on;
    logic [2:0] play_track;
    logic       stop_voice;
    logic       dismissed;
  } result_t;

  // Number of steps in the beep pattern of level 6 + li.
  function automatic logic [2:0] beep_len(input logic [2:0] li);
    logic [2:0] len;
    unique case (li)
      3'd0:    len = 3'd2;
      3'd1:    len = 3'd3;
      3'd2:    len = 3'd4;
      3'd3:    len = 3'd3;
      3'd4:    len = 3'd1;
      default: len = 3'd1;
    endcase
    return len;
  endfunction

  // Step number folded into the pattern length.
  function automatic logic [1:0] beep_fold(input logic [2:0] li, input logic [1:0] step);
    logic [1:0] s;
    unique case (beep_len(li))
      3'd1:    s = 2'd0;
      3'd2:    s = {1'b0, step[0]};
      3'd3:    s = (step == 2'd3) ? 2'd0 : step;
      default: s = step;
    endcase
    return s;
  endfunction

  // On time of a beep step, in ms; the step is already folded.
  function automatic logic [CFG_BITS-1:0] beep_on_ms(input logic [2:0] li,
                                                     input logic [1:0] s);
    logic [CFG_BITS-1:0] ms;
    unique case (li)
      3'd0:    ms = 10'd100;
      3'd1:    ms = 10'd220;
      3'd2:    ms = 10'd320;
      3'd3:    ms = 10'd120;
      default: ms = 10'd70;
    endcase
    if (s == 2'd3) begin
      ms = ms;
    end
    return ms;
  endfunction

  // Off time of a beep step, in ms; the step is already folded.
  function automatic logic [CFG_BITS-1:0] beep_off_ms(input logic [2:0] li,
                                                      input logic [1:0] s);
    logic [CFG_BITS-1:0] ms;
    unique case (li)
      3'd0:    ms = (s == 2'd1) ? 10'd900 : 10'd100;
      3'd1:    ms = (s == 2'd2) ? 10'd650 : 10'd150;
      3'd2:    ms = (s == 2'd3) ? 10'd280 : 10'd120;
      3'd3:    ms = (s == 2'd2) ? 10'd450 : 10'd80;
      default: ms = 10'd55;
    endcase
    return ms;
  endfunction

endpackage

`default_nettype wire

>>> rtl/aps_if.sv
// Handshake channel interfaces of the alert pattern sequencer: request input
// channel and result channel. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface aps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [3:0] level;
  logic       button_pressed;

  modport source (output valid, output operation, output level, output button_pressed,
                  input ready);
  modport sink (input valid, input operation, input level, input button_pressed,
                output ready);
endinterface

interface aps_out_if;
  logic       valid;
  logic       ready;
  logic       buzzer;
  logic       led_main;
  logic       led_second;
  logic       alert_on;
  logic [2:0] play_track;
  logic       stop_voice;
  logic       dismissed;

  modport source (output valid, output buzzer, output led_main, output led_second,
                  output alert_on, output play_track, output stop_voice,
                  output dismissed, input ready);
  modport sink (input valid, input buzzer, input led_main, input led_second,
                input alert_on, input play_track, input stop_voice, input dismissed,
                output ready);
endinterface

`default_nettype wire

>>> rtl/alert_pattern_sequencer_core.sv
// Alert pattern sequencer: buzzer and two LEDs driven from alert level requests
// and 1 ms ticks. Takes one request per clock while the sink takes results; each
// request is registered on entry and its result is registered on exit, so a
// result passes the request register and then the output register. The request
// register lets one more request in while a result waits for the sink, and the
// state update in the engine sets the rate of one request per cycle.
// The user must write configuration through cfg_we/cfg_index/cfg_wdata only
// while no request is in flight; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module alert_pattern_sequencer_core #(
  parameter int TIMER_BITS = aps_pkg::TIMER_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  aps_in_if.sink                        in_ch,
  aps_out_if.source                     out_ch,
  input  wire logic                     cfg_we,
  input  wire logic [2:0]               cfg_index,
  input  wire logic [aps_pkg::CFG_BITS-1:0] cfg_wdata
);

  aps_pkg::cfg_t     cfg_r;
  aps_pkg::in_item_t in_item_r;
  logic              in_valid_r;
  aps_pkg::result_t  result;
  aps_pkg::result_t  out_item_r;
  logic              out_valid_r;
  logic              advance;
  logic              in_take;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= aps_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aps_pkg::CFG_DEBOUNCE:     cfg_r.debounce_ms        <= cfg_wdata;
        aps_pkg::CFG_FLASH_PERIOD: cfg_r.flash_period_ms    <= cfg_wdata;
        aps_pkg::CFG_PULSE_SHORT:  cfg_r.pulse_on_short_ms  <= cfg_wdata;
        aps_pkg::CFG_PULSE_MEDIUM: cfg_r.pulse_on_medium_ms <= cfg_wdata;
        aps_pkg::CFG_PULSE_LONG:   cfg_r.pulse_on_long_ms   <= cfg_wdata;
        aps_pkg::CFG_PULSE_OFF:    cfg_r.pulse_off_ms       <= cfg_wdata;
        aps_pkg::CFG_PULSE_COUNT:  cfg_r.pulse_count        <= cfg_wdata[1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.operation      <= in_ch.operation;
      in_item_r.level          <= in_ch.level;
      in_item_r.button_pressed <= in_ch.button_pressed;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

  aps_engine #(
    .TIMER_BITS (TIMER_BITS)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_item_r),
    .cfg     (cfg_r),
    .result  (result)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.buzzer     = out_item_r.buzzer;
  assign out_ch.led_main   = out_item_r.led_main;
  assign out_ch.led_second = out_item_r.led_second;
  assign out_ch.alert_on   = out_item_r.alert_on;
  assign out_ch.play_track = out_item_r.play_track;
  assign out_ch.stop_voice = out_item_r.stop_voice;
  assign out_ch.dismissed  = out_item_r.dismissed;

endmodule

`default_nettype wire

>>> rtl/aps_engine.sv
// Alert state and pattern machines: holds the timers and pin levels and applies
// one request per enabled cycle. Depends on aps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aps_engine #(
  parameter int TIMER_BITS = aps_pkg::TIMER_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step_en,
  input  wire aps_pkg::in_item_t item,
  input  wire aps_pkg::cfg_t    cfg,
  output aps_pkg::result_t      result
);

  localparam logic [TIMER_BITS-1:0] TMAX = '1;

  logic                  active_r, active_nxt;
  logic [3:0]            level_r, level_nxt;
  logic [1:0]            pulses_left_r, pulses_left_nxt;
  logic                  pulse_on_r, pulse_on_nxt;
  logic [TIMER_BITS-1:0] pulse_el_r, pulse_el_nxt;
  logic                  flash_r, flash_nxt;
  logic [TIMER_BITS-1:0] flash_el_r, flash_el_nxt;
  logic [1:0]            beep_step_r, beep_step_nxt;
  logic                  beep_on_r, beep_on_nxt;
  logic [TIMER_BITS-1:0] beep_el_r, beep_el_nxt;
  logic [TIMER_BITS-1:0] since_press_r, since_press_nxt;
  logic [2:0]            pins_r, pins_nxt;

  logic [2:0]            li;
  logic [1:0]            bstep;
  logic [2:0]            blen;
  logic [9:0]            pulse_on_ms;
  logic [2:0]            track;
  logic                  stopv;
  logic                  dism;

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] t);
    return (t == TMAX) ? t : t + TIMER_BITS'(1);
  endfunction

  assign li    = 3'(level_r - aps_pkg::LVL_FIRST);
  assign bstep = aps_pkg::beep_fold(li, beep_step_r);
  assign blen  = aps_pkg::beep_len(li);

  always_comb begin
    unique case (level_r)
      4'd7:    pulse_on_ms = cfg.pulse_on_medium_ms;
      4'd8:    pulse_on_ms = cfg.pulse_on_long_ms;
      default: pulse_on_ms = cfg.pulse_on_short_ms;
    endcase
  end

  always_comb begin
    active_nxt      = active_r;
    level_nxt       = level_r;
    pulses_left_nxt = pulses_left_r;
    pulse_on_nxt    = pulse_on_r;
    pulse_el_nxt    = pulse_el_r;
    flash_nxt       = flash_r;
    flash_el_nxt    = flash_el_r;
    beep_step_nxt   = beep_step_r;
    beep_on_nxt     = beep_on_r;
    beep_el_nxt     = beep_el_r;
    since_press_nxt = since_press_r;
    pins_nxt        = pins_r;
    track           = 3'd0;
    stopv           = 1'b0;
    dism            = 1'b0;

    unique case (item.operation)
      aps_pkg::OP_TICK: begin
        pulse_el_nxt    = sat_inc(pulse_el_r);
        flash_el_nxt    = sat_inc(flash_el_r);
        beep_el_nxt     = sat_inc(beep_el_r);
        since_press_nxt = sat_inc(since_press_r);

        // LED pulses, levels 6 to 8 while pulses remain.
        if (active_r && level_r >= aps_pkg::LVL_FIRST && level_r <= aps_pkg::LVL_PULSED &&
            pulses_left_r != 2'd0) begin
          if (pulse_on_r) begin
            if (pulse_el_nxt >= TIMER_BITS'(pulse_on_ms)) begin
              pulse_on_nxt              = 1'b0;
              pulse_el_nxt              = '0;
              pulses_left_nxt           = pulses_left_r - 2'd1;
              pins_nxt[aps_pkg::PIN_MAIN] = 1'b0;
              pins_nxt[aps_pkg::PIN_SEC]  = 1'b0;
            end
          end else if (pulse_el_nxt >= TIMER_BITS'(cfg.pulse_off_ms)) begin
            pulse_on_nxt              = 1'b1;
            pulse_el_nxt              = '0;
            pins_nxt[aps_pkg::PIN_MAIN] = 1'b1;
            pins_nxt[aps_pkg::PIN_SEC]  = 1'b1;
          end
        end

        // Main LED flashing at the top level.
        if (active_r && level_r == aps_pkg::LVL_FLASH &&
            flash_el_nxt >= TIMER_BITS'(cfg.flash_period_ms)) begin
          flash_el_nxt              = '0;
          flash_nxt                 = !flash_r;
          pins_nxt[aps_pkg::PIN_MAIN] = !flash_r;
        end

        // Beep pattern; a step advances when its off phase ends.
        if (active_r && level_r >= aps_pkg::LVL_FIRST && level_r <= aps_pkg::LVL_FLASH) begin
          if (beep_on_r) begin
            if (beep_el_nxt >= TIMER_BITS'(aps_pkg::beep_on_ms(li, bstep))) begin
              pins_nxt[aps_pkg::PIN_BUZ] = 1'b0;
              beep_on_nxt                = 1'b0;
              beep_el_nxt                = '0;
            end
          end else if (beep_el_nxt >= TIMER_BITS'(aps_pkg::beep_off_ms(li, bstep))) begin
            beep_step_nxt              = (3'({1'b0, bstep} + 3'd1) == blen) ? 2'd0
                                                                            : bstep + 2'd1;
            beep_on_nxt                = 1'b1;
            beep_el_nxt                = '0;
            pins_nxt[aps_pkg::PIN_BUZ] = 1'b1;
          end
        end

        // A saturated press timer always counts as long enough ago.
        if (active_r && item.button_pressed &&
            (since_press_nxt > TIMER_BITS'(cfg.debounce_ms) || since_press_nxt == TMAX)) begin
          since_press_nxt = '0;
          active_nxt      = 1'b0;
          level_nxt       = 4'd0;
          pins_nxt        = 3'd0;
          pulses_left_nxt = 2'd0;
          pulse_on_nxt    = 1'b0;
          flash_nxt       = 1'b0;
          beep_step_nxt   = 2'd0;
          beep_on_nxt     = 1'b0;
          stopv           = 1'b1;
          dism            = 1'b1;
        end
      end

      aps_pkg::OP_BUZZ: begin
        if (item.level >= aps_pkg::LVL_FIRST && item.level <= aps_pkg::LVL_FLASH) begin
          stopv         = 1'b1;
          active_nxt    = 1'b1;
          level_nxt     = item.level;
          track         = 3'(item.level - aps_pkg::TRACK_BASE);
          beep_step_nxt = 2'd0;
          beep_on_nxt   = 1'b1;
          beep_el_nxt   = '0;
          pulse_el_nxt  = '0;
          flash_el_nxt  = '0;
          if (item.level > aps_pkg::LVL_PULSED) begin
            pulses_left_nxt = 2'd0;
            pulse_on_nxt    = 1'b0;
            flash_nxt       = (item.level == aps_pkg::LVL_FLASH);
            pins_nxt        = 3'b111;
          end else begin
            pulses_left_nxt = cfg.pulse_count;
            pulse_on_nxt    = (cfg.pulse_count != 2'd0);
            flash_nxt       = 1'b0;
            pins_nxt        = {pulse_on_nxt, pulse_on_nxt, 1'b1};
          end
        end
      end

      aps_pkg::OP_CLEAR: begin
        active_nxt      = 1'b0;
        level_nxt       = 4'd0;
        pins_nxt        = 3'd0;
        pulses_left_nxt = 2'd0;
        pulse_on_nxt    = 1'b0;
        flash_nxt       = 1'b0;
        beep_step_nxt   = 2'd0;
        beep_on_nxt     = 1'b0;
        stopv           = 1'b1;
      end

      default: begin
      end
    endcase
  end

  always_comb begin
    result.buzzer     = pins_nxt[aps_pkg::PIN_BUZ];
    result.led_main   = pins_nxt[aps_pkg::PIN_MAIN];
    result.led_second = pins_nxt[aps_pkg::PIN_SEC];
    result.alert_on   = active_nxt;
    result.play_track = track;
    result.stop_voice = stopv;
    result.dismissed  = dism;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= 1'b0;
      level_r       <= 4'd0;
      pulses_left_r <= 2'd0;
      pulse_on_r    <= 1'b0;
      pulse_el_r    <= '0;
      flash_r       <= 1'b0;
      flash_el_r    <= '0;
      beep_step_r   <= 2'd0;
      beep_on_r     <= 1'b0;
      beep_el_r     <= '0;
      since_press_r <= TMAX;
      pins_r        <= 3'd0;
    end else if (step_en) begin
      active_r      <= active_nxt;
      level_r       <= level_nxt;
      pulses_left_r <= pulses_left_nxt;
      pulse_on_r    <= pulse_on_nxt;
      pulse_el_r    <= pulse_el_nxt;
      flash_r       <= flash_nxt;
      flash_el_r    <= flash_el_nxt;
      beep_step_r   <= beep_step_nxt;
      beep_on_r     <= beep_on_nxt;
      beep_el_r     <= beep_el_nxt;
      since_press_r <= since_press_nxt;
      pins_r        <= pins_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/aps_checker.sv
// Port-level checks of the alert pattern sequencer, bound to the top level.
// Depends on assert_macros.svh and alert_pattern_sequencer_core.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module aps_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       buzzer,
  input wire logic       led_main,
  input wire logic       led_second,
  input wire logic       alert_on,
  input wire logic [2:0] play_track,
  input wire logic       stop_voice,
  input wire logic       dismissed
);

  logic [8:0] out_bits;

  assign out_bits = {buzzer, led_main, led_second, alert_on, play_track, stop_voice,
                     dismissed};

  `APS_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(out_bits), "result changed while stalled")
  `APS_ASSERT(a_dismiss_clears, out_valid && dismissed |-> stop_voice && !alert_on, "dismiss left the alert active")
  `APS_ASSERT(a_track_start, out_valid && play_track != 3'd0 |-> alert_on && buzzer && stop_voice, "track started without an alert")
  `APS_ASSERT(a_idle_dark, out_valid && !alert_on |-> !buzzer && !led_main && !led_second, "outputs driven with no alert")
  `APS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind alert_pattern_sequencer_core aps_checker u_aps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .buzzer     (out_ch.buzzer),
  .led_main   (out_ch.led_main),
  .led_second (out_ch.led_second),
  .alert_on   (out_ch.alert_on),
  .play_track (out_ch.play_track),
  .stop_voice (out_ch.stop_voice),
  .dismissed  (out_ch.dismissed)
);

`default_nettype wire
